@@ design/kfe_pkg.sv @@
// Shared types, codes and helpers for the K-character frame extractor.
package kfe_pkg;

	localparam int SYM_W      = 8;
	localparam int CODE_W     = 8;
	localparam int FLEN_W     = 12;
	localparam int IDX_W      = 12;
	localparam int MLEN_W     = 12;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam int EXT_W      = 16;

	localparam int LENGTH_BITS_DEF   = 12;
	localparam int TRAILER_BYTES_DEF = 4;

	localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST = 12'd468;
	localparam logic [CODE_W-1:0] START_CODE_RST   = 8'd0;

	localparam logic [CFG_IDX_W-1:0] REG_START_CODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd1;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_RUN   = 2'd1,
		PH_BODY  = 2'd2,
		PH_TRAIL = 2'd3
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_START = 2'd1,
		ST_SHORT     = 2'd2
	} status_t;

	typedef struct packed {
		logic                byte_valid;
		logic [SYM_W-1:0]    out_byte;
		logic [IDX_W-1:0]    byte_index;
		logic                frame_done;
		status_t             frame_status;
		logic [MLEN_W-1:0]   measured_length;
		logic [MLEN_W-1:0]   excess_bytes;
	} result_t;

	function automatic logic [MLEN_W-1:0] cap12(input logic [EXT_W-1:0] v);
		logic [EXT_W-1:0] lim;
		lim = EXT_W'({MLEN_W{1'b1}});
		cap12 = (v > lim) ? {MLEN_W{1'b1}} : v[MLEN_W-1:0];
	endfunction

endpackage

@@ design/kfe_frame_fsm.sv @@
// Framing state machine: config registers, frame state and per-symbol result.
module kfe_frame_fsm #(
	parameter int LENGTH_BITS   = kfe_pkg::LENGTH_BITS_DEF,
	parameter int TRAILER_BYTES = kfe_pkg::TRAILER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                accept,
	input  logic [kfe_pkg::SYM_W-1:0]           symbol_byte,
	input  logic                                is_control,
	output logic                                has_result,
	output kfe_pkg::result_t                    result
);
	import kfe_pkg::*;

	localparam int TRL_W = (TRAILER_BYTES < 2) ? 1 : $clog2(TRAILER_BYTES + 1);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [TRL_W-1:0] TRL_END = TRL_W'(TRAILER_BYTES);

	logic [CODE_W-1:0]      start_code_q;
	logic [FLEN_W-1:0]      frame_length_q;
	phase_t                 phase_q, phase_d;
	logic [CODE_W-1:0]      held_q, held_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [TRL_W-1:0]       trl_q, trl_d;

	logic [LENGTH_BITS-1:0] len_cur;
	logic [LENGTH_BITS-1:0] len_inc;
	logic [EXT_W-1:0]       len_cur_x;
	logic [EXT_W-1:0]       len_inc_x;
	logic [EXT_W-1:0]       flen_x;
	logic                   in_window;
	logic                   inc_short;
	logic [TRL_W-1:0]       trl_inc;
	logic                   start_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q   <= START_CODE_RST;
			frame_length_q <= FRAME_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_CODE:   start_code_q   <= cfg_data[CODE_W-1:0];
				REG_FRAME_LENGTH: frame_length_q <= cfg_data[FLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			held_q  <= '0;
			len_q   <= '0;
			trl_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			len_q   <= len_d;
			trl_q   <= trl_d;
		end
	end

	// count taken by the current symbol; a frame start restarts at one
	assign start_ok  = (held_q == start_code_q);
	assign len_cur   = (phase_q == PH_RUN) ? LENGTH_BITS'(1) : len_q;
	assign len_inc   = (len_cur < LEN_MAX) ? len_cur + LENGTH_BITS'(1) : len_cur;
	assign len_cur_x = EXT_W'(len_cur);
	assign len_inc_x = EXT_W'(len_inc);
	assign flen_x    = EXT_W'(frame_length_q);
	assign in_window = (len_cur_x < flen_x);
	assign inc_short = (len_inc_x < flen_x);
	assign trl_inc   = trl_q + TRL_W'(1);

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		len_d   = len_q;
		trl_d   = trl_q;
		case (phase_q)
			PH_HUNT: begin
				if (is_control) begin
					held_d  = symbol_byte;
					phase_d = PH_RUN;
				end
			end
			PH_RUN: begin
				if (is_control) begin
					held_d = symbol_byte;
				end else if (!start_ok) begin
					phase_d = PH_HUNT;
				end else begin
					len_d   = len_inc;
					trl_d   = '0;
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				len_d = len_inc;
				if (is_control) begin
					if (TRL_W'(1) >= TRL_END) begin
						trl_d   = '0;
						phase_d = PH_HUNT;
					end else begin
						trl_d   = TRL_W'(1);
						phase_d = PH_TRAIL;
					end
				end
			end
			PH_TRAIL: begin
				len_d = len_inc;
				if (trl_inc >= TRL_END) begin
					trl_d   = '0;
					phase_d = PH_HUNT;
				end else begin
					trl_d = trl_inc;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		logic take;
		logic fin;
		take   = 1'b0;
		fin    = 1'b0;
		result = '0;
		case (phase_q)
			PH_HUNT: ;
			PH_RUN: begin
				if (!is_control && !start_ok) begin
					result.frame_done   = 1'b1;
					result.frame_status = ST_BAD_START;
				end else if (!is_control) begin
					take = 1'b1;
				end
			end
			PH_BODY: begin
				take = 1'b1;
				fin  = is_control && (TRL_W'(1) >= TRL_END);
			end
			PH_TRAIL: begin
				take = 1'b1;
				fin  = (trl_inc >= TRL_END);
			end
			default: ;
		endcase
		if (take && in_window) begin
			result.byte_valid = 1'b1;
			result.out_byte   = symbol_byte;
			result.byte_index = IDX_W'(len_cur);
		end
		if (fin) begin
			result.frame_done      = 1'b1;
			result.measured_length = cap12(len_inc_x);
			if (inc_short) begin
				result.frame_status = ST_SHORT;
			end else begin
				result.frame_status = ST_OK;
				result.excess_bytes = cap12(len_inc_x - flen_x);
			end
		end
		has_result = result.byte_valid | result.frame_done;
	end

endmodule

@@ design/kfe_out_stage.sv @@
// Output register holding one result transaction until downstream takes it.
module kfe_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  kfe_pkg::result_t result,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             hold,
	output kfe_pkg::result_t out_data
);
	import kfe_pkg::*;

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign hold      = valid_q & out_stall;
	assign out_data  = data_q;

endmodule

@@ design/kchar_frame_extractor.sv @@
// Top level of the K-character frame extractor.
//
//   port group   direction  transaction when            payload
//   in           sink       in_valid && !in_stall       symbol_byte, is_control
//   out          source     out_valid && !out_stall     byte_valid .. excess_bytes
//   cfg          sink       cfg_we                      cfg_index, cfg_data
//
// One symbol per cycle while in_stall is low; each result appears in the cycle after its symbol.
// The result is held in the single output register behind the framing logic.
// Reset returns to hunting with registers at start code 0, length 468.
// in_stall is high only while a result waits in the output register and
// out_stall is high.
module kchar_frame_extractor #(
	parameter int LENGTH_BITS   = kfe_pkg::LENGTH_BITS_DEF,
	parameter int TRAILER_BYTES = kfe_pkg::TRAILER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kfe_pkg::SYM_W-1:0]           symbol_byte,
	input  logic                                is_control,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                byte_valid,
	output logic [kfe_pkg::SYM_W-1:0]           out_byte,
	output logic [kfe_pkg::IDX_W-1:0]           byte_index,
	output logic                                frame_done,
	output logic [kfe_pkg::STATUS_W-1:0]        frame_status,
	output logic [kfe_pkg::MLEN_W-1:0]          measured_length,
	output logic [kfe_pkg::MLEN_W-1:0]          excess_bytes
);
	import kfe_pkg::*;

	logic    accept;
	logic    has_result;
	logic    hold;
	result_t result;
	result_t out_data;

	assign in_stall = hold;
	assign accept   = in_valid & ~hold;

	kfe_frame_fsm #(
		.LENGTH_BITS   (LENGTH_BITS),
		.TRAILER_BYTES (TRAILER_BYTES)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.symbol_byte (symbol_byte),
		.is_control  (is_control),
		.has_result  (has_result),
		.result      (result)
	);

	kfe_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept & has_result),
		.result    (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.hold      (hold),
		.out_data  (out_data)
	);

	assign byte_valid      = out_data.byte_valid;
	assign out_byte        = out_data.out_byte;
	assign byte_index      = out_data.byte_index;
	assign frame_done      = out_data.frame_done;
	assign frame_status    = out_data.frame_status;
	assign measured_length = out_data.measured_length;
	assign excess_bytes    = out_data.excess_bytes;

endmodule
